>>> sv/lpht_pkg.sv
// lpht_pkg: item types, slot layout and operation/status codes for the
// linear probe hash table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_UPDATE = 2'd3;

	// slot status codes
	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_USED  = 2'd1;
	localparam logic [1:0] ST_TOMB  = 2'd2;

	// one request item
	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] key;
		logic [31:0]        record_value;
	} req_t;

	// one result item
	typedef struct packed {
		logic        ok;
		logic [31:0] found_value;
		logic [5:0]  slot_index;
		logic [6:0]  live_count;
	} res_t;

	// one table slot as held in the slot memory
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] key;
		logic [31:0] payload;
	} slot_t;

endpackage

`default_nettype wire

>>> sv/lpht_ram.sv
// lpht_ram: generic single write port, single read port RAM with a
// registered read. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> sv/lpht_queue.sv
// lpht_queue: two-entry queue that carries hashed items from the front
// part to the probe engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lpht_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [WIDTH-1:0] din,
	output logic                  valid,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] dout
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign dout    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

>>> sv/lpht_front.sv
// lpht_front: accepts request items and computes the home slot
// (key squared, reduced modulo the slot count). Depends on lpht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpht_front #(
	parameter int TABLE_SLOTS = 64,
	localparam int AW = $clog2(TABLE_SLOTS)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire lpht_pkg::req_t  request,
	input  wire logic            clearing,
	output logic                 q_push,
	input  wire logic            q_full,
	output lpht_pkg::req_t       q_req,
	output logic      [AW-1:0]   q_home
);

	typedef enum logic [2:0] {
		F_IDLE,
		F_SQUARE,
		F_RECIP,
		F_BACK,
		F_FIX,
		F_PUSH
	} fstate_t;

	// slot count and its reciprocal, floor(2^32 / slots)
	localparam logic [31:0] SLOTS_W = 32'(TABLE_SLOTS);
	localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / TABLE_SLOTS);

	fstate_t          state_q;
	lpht_pkg::req_t   req_q;
	logic [31:0]      sq_q;
	logic [31:0]      quot_q;
	logic [AW:0]      rem_q;
	logic [AW-1:0]    home_q;
	logic [31:0]      key_bits;
	logic [31:0]      sq_d;
	logic [63:0]      prod_d;
	logic [31:0]      back_d;
	logic [AW:0]      fix_d;

	assign full   = (state_q != F_IDLE) || clearing;
	assign q_push = (state_q == F_PUSH);
	assign q_req  = req_q;
	assign q_home = home_q;

	// low word of key squared, same for signed and unsigned operands
	assign key_bits = $unsigned(req_q.key);
	assign sq_d     = key_bits * key_bits;

	// quotient estimate from the reciprocal, low by at most one
	assign prod_d = 64'(sq_q) * 64'(RECIP);

	// remainder from the estimate, below twice the slot count
	assign back_d = sq_q - quot_q * SLOTS_W;

	// one correcting subtract brings the remainder into range
	always_comb begin
		if (rem_q >= (AW+1)'(TABLE_SLOTS)) begin
			fix_d = rem_q - (AW+1)'(TABLE_SLOTS);
		end else begin
			fix_d = rem_q;
		end
	end

	// sequencer: capture, square, estimate, remainder, correct, hand to queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			req_q   <= '0;
			sq_q    <= '0;
			quot_q  <= '0;
			rem_q   <= '0;
			home_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push && !full) begin
						req_q   <= request;
						state_q <= F_SQUARE;
					end
				end
				F_SQUARE: begin
					sq_q    <= sq_d;
					state_q <= F_RECIP;
				end
				F_RECIP: begin
					quot_q  <= prod_d[63:32];
					state_q <= F_BACK;
				end
				F_BACK: begin
					rem_q   <= back_d[AW:0];
					state_q <= F_FIX;
				end
				F_FIX: begin
					home_q  <= fix_d[AW-1:0];
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/lpht_back.sv
// lpht_back: probe engine over the slot memory, live counter and result
// register; clears the slot memory after reset. Depends on lpht_pkg, lpht_ram.
`timescale 1ns / 1ps
`default_nettype none

module lpht_back #(
	parameter int TABLE_SLOTS = 64,
	localparam int AW = $clog2(TABLE_SLOTS)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire lpht_pkg::req_t  q_req,
	input  wire logic [AW-1:0]   q_home,
	output logic                 q_pop,
	output logic                 clearing,
	output logic                 empty,
	input  wire logic            pop,
	output lpht_pkg::res_t       result
);

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_PROBE
	} bstate_t;

	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);

	bstate_t          state_q;
	lpht_pkg::req_t   cur_q;
	logic [AW-1:0]    check_ptr_q;
	logic [AW-1:0]    cnt_q;
	logic [AW-1:0]    clr_q;
	logic [6:0]       count_q;
	logic             out_valid_q;
	lpht_pkg::res_t   res_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	lpht_pkg::slot_t  ram_wdata;
	logic [AW-1:0]    ram_raddr;
	lpht_pkg::slot_t  rd;

	logic             is_used;
	logic             is_empty;
	logic             hit;
	logic             stop;
	logic             done;
	logic [6:0]       count_d;
	lpht_pkg::res_t   res_d;
	logic [AW+5:0]    ptr_wide;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	assign clearing = (state_q == B_CLEAR);
	assign empty    = !out_valid_q;
	assign result   = res_q;
	assign q_pop    = (state_q == B_IDLE) && q_valid && (!out_valid_q || pop);

	// read the home slot on start, otherwise the slot after the one checked
	assign ram_raddr = (state_q == B_IDLE) ? q_home : next_slot(check_ptr_q);

	lpht_ram #(
		.WIDTH ($bits(lpht_pkg::slot_t)),
		.DEPTH (TABLE_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd)
	);

	// classify the slot read last cycle
	always_comb begin
		is_used  = (rd.status == lpht_pkg::ST_USED);
		is_empty = (rd.status == lpht_pkg::ST_EMPTY);
		if (cur_q.operation == lpht_pkg::OP_INSERT) begin
			hit  = !is_used;
			stop = hit || (cnt_q == LAST_SLOT);
		end else begin
			hit  = is_used && (rd.key == $unsigned(cur_q.key));
			stop = hit || is_empty || (cnt_q == LAST_SLOT);
		end
		done = (state_q == B_PROBE) && stop;
	end

	// slot write and counter update
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = check_ptr_q;
		ram_wdata = rd;
		count_d   = count_q;
		if (state_q == B_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '{status: lpht_pkg::ST_EMPTY, key: '0, payload: '0};
		end else if (done && hit) begin
			case (cur_q.operation)
				lpht_pkg::OP_INSERT: begin
					ram_we    = 1'b1;
					ram_wdata = '{status: lpht_pkg::ST_USED,
						key: $unsigned(cur_q.key), payload: cur_q.record_value};
					count_d   = count_q + 1'b1;
				end
				lpht_pkg::OP_DELETE: begin
					ram_we           = 1'b1;
					ram_wdata.status = lpht_pkg::ST_TOMB;
					count_d          = count_q - 1'b1;
				end
				lpht_pkg::OP_UPDATE: begin
					ram_we            = 1'b1;
					ram_wdata.payload = cur_q.record_value;
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end
	end

	// result item
	always_comb begin
		ptr_wide         = {6'd0, check_ptr_q};
		res_d.ok         = hit;
		res_d.found_value = (hit && (cur_q.operation == lpht_pkg::OP_LOOKUP ||
			cur_q.operation == lpht_pkg::OP_DELETE)) ? rd.payload : 32'd0;
		res_d.slot_index = hit ? ptr_wide[5:0] : 6'd0;
		res_d.live_count = count_d;
	end

	// sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			cur_q       <= '0;
			check_ptr_q <= '0;
			cnt_q       <= '0;
			clr_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SLOT) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (q_pop) begin
						cur_q       <= q_req;
						check_ptr_q <= q_home;
						cnt_q       <= '0;
						state_q     <= B_PROBE;
					end
				end
				B_PROBE: begin
					if (stop) begin
						count_q     <= count_d;
						res_q       <= res_d;
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end else begin
						check_ptr_q <= next_slot(check_ptr_q);
						cnt_q       <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// a finished item never lands on a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !out_valid_q)
		else $error("result register overwritten");

	// no item is taken or delivered during the clearing pass
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CLEAR) |-> (!q_pop && !out_valid_q))
		else $error("activity during clearing pass");

	// the live counter moves only when an item finishes
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!done |=> $stable(count_q))
		else $error("live counter changed without a finished item");

	// a failed item reports no value and no slot
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |=> (res_q.found_value == 32'd0 && res_q.slot_index == 6'd0))
		else $error("failed item reports value or slot");

endmodule

`default_nettype wire

>>> sv/linear_probe_hash_table_core.sv
// linear_probe_hash_table_core: top level, joins the hashing front part,
// the item queue and the probe engine. Depends on lpht_pkg and all lpht modules.
`timescale 1ns / 1ps
`default_nettype none

// Open-addressing hash table of TABLE_SLOTS slots with linear probing.
// Requests (insert, lookup, delete, update) are pushed while full is low and
// results are popped while empty is low, one result per request, in order.
// The front part squares the key and reduces it modulo the slot count with a
// reciprocal multiply and one correcting subtract, and hands it on through a
// two-entry queue; it overlaps with the probe engine. The probe engine reads
// one slot a cycle from the slot memory and examines 1 to TABLE_SLOTS slots
// per item. The slower of the two parts sets the sustained rate. After reset
// the slot memory is swept to empty, during which full stays high. Duplicate
// keys are stored again on insert; the live count is 7 bits wide.
module linear_probe_hash_table_core #(
	parameter int TABLE_SLOTS = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire lpht_pkg::req_t  request,
	output logic                 empty,
	input  wire logic            pop,
	output lpht_pkg::res_t       result
);

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int QW = $bits(lpht_pkg::req_t) + AW;

	logic            clearing;
	logic            f_push;
	logic            f_full;
	lpht_pkg::req_t  f_req;
	logic [AW-1:0]   f_home;
	logic            b_valid;
	logic            b_pop;
	logic [QW-1:0]   q_din;
	logic [QW-1:0]   q_dout;
	lpht_pkg::req_t  b_req;
	logic [AW-1:0]   b_home;

	assign q_din  = {f_req, f_home};
	assign b_req  = lpht_pkg::req_t'(q_dout[QW-1:AW]);
	assign b_home = q_dout[AW-1:0];

	lpht_front #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.clearing (clearing),
		.q_push   (f_push),
		.q_full   (f_full),
		.q_req    (f_req),
		.q_home   (f_home)
	);

	lpht_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.full   (f_full),
		.din    (q_din),
		.valid  (b_valid),
		.pop    (b_pop),
		.dout   (q_dout)
	);

	lpht_back #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (b_valid),
		.q_req    (b_req),
		.q_home   (b_home),
		.q_pop    (b_pop),
		.clearing (clearing),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire
